// ===== sv/p2fla_pkg.sv =====
package p2fla_pkg;

    localparam int REQ_W    = 16;
    localparam int ADDR_W   = 16;
    localparam int BYTES_W  = 17;
    localparam int CLS_W    = 5;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMEM   = 2'd1,
        ST_BADFREE = 2'd2
    } status_t;

    typedef enum logic [7:0] {
        S_CLR   = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DEC   = 8'b0000_0100,
        S_SRCH  = 8'b0000_1000,
        S_POP   = 8'b0001_0000,
        S_SPLIT = 8'b0010_0000,
        S_FCHK  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    // per-granule block info: class 0 means no block starts here
    typedef struct packed {
        logic             free;
        logic [CLS_W-1:0] cls;
    } meta_t;

    function automatic logic [CLS_W-1:0] ceil_log2_17(input logic [BYTES_W-1:0] v);
        logic [BYTES_W-1:0] m;
        logic [CLS_W-1:0]   p;
        m = v - BYTES_W'(1);
        p = '0;
        for (int i = 0; i < BYTES_W; i++)
        begin
            if (m[i])
            begin
                p = CLS_W'(i + 1);
            end
        end
        if (v <= BYTES_W'(1))
        begin
            p = '0;
        end
        return p;
    endfunction

endpackage

// ===== sv/p2fla_ram.sv =====
module p2fla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/power_of_two_free_list_allocator_core.sv =====
// Allocate: searches the class stacks from the needed class upward, pops a block from the
// first non-empty one, then halves it down to the needed class (up to eleven halvings at
// default sizes), one stack push each; a too-large request goes from decode straight to the
// result. Free: a null or invalid address goes from decode straight to the result, a valid
// one is checked in the block table first. One item in flight; the next is accepted the cycle
// after the result loads into the output register, even while that result is stalled. Reset
// (async, active low) clears all 2^(POOL_LOG-MIN_LOG) block table entries, accepting no item.
module power_of_two_free_list_allocator_core #(
    parameter int POOL_LOG     = 16,
    parameter int MIN_LOG      = 5,
    parameter int HEADER_BYTES = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           mode,
    input  logic [p2fla_pkg::REQ_W-1:0]    request_bytes,
    input  logic [p2fla_pkg::ADDR_W-1:0]   free_address,
    output logic                           out_valid,
    input  logic                           out_stall,
    output p2fla_pkg::status_t             status,
    output logic [p2fla_pkg::ADDR_W-1:0]   data_address,
    output logic [p2fla_pkg::BYTES_W-1:0]  used_bytes,
    output logic [p2fla_pkg::BYTES_W-1:0]  free_bytes
);

    import p2fla_pkg::*;

    localparam int GB = POOL_LOG - MIN_LOG;
    localparam int NC = GB + 1;
    localparam int GW = (GB > 0) ? GB : 1;
    localparam int SW = GB + 1;
    localparam int KW = (NC > 1) ? $clog2(NC) : 1;
    localparam int UW = POOL_LOG + 1;
    localparam logic [SW-1:0] GRAN_CNT  = SW'(64'd1 << GB);
    localparam logic [UW-1:0] POOL_SIZE = UW'(64'd1 << POOL_LOG);
    localparam logic [KW-1:0] TOP_K     = KW'(GB);

    function automatic logic [SW-1:0] stk_base(input logic [KW-1:0] k);
        return SW'(0) - ((GRAN_CNT >> k) << 1);
    endfunction

    state_t               state_reg, state_next;
    logic                 mode_reg, mode_next;
    logic [REQ_W-1:0]     req_reg, req_next;
    logic [ADDR_W-1:0]    faddr_reg, faddr_next;
    logic [KW-1:0]        need_k_reg, need_k_next;
    logic [KW-1:0]        k_reg, k_next;
    logic [GW-1:0]        g_reg, g_next;
    logic [GW-1:0]        clr_reg, clr_next;
    logic [SW-1:0]        cnt_reg [NC];
    logic [UW-1:0]        used_reg, used_next;
    status_t              res_status_reg, res_status_next;
    logic [ADDR_W-1:0]    res_addr_reg, res_addr_next;
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg;
    logic [ADDR_W-1:0]    data_address_reg;
    logic [BYTES_W-1:0]   used_bytes_reg, free_bytes_reg;

    logic                 load;
    logic [KW-1:0]        cnt_idx;
    logic [SW-1:0]        cnt_rd;
    logic                 cnt_we;
    logic [SW-1:0]        cnt_wdata;

    logic                 m_we;
    logic [GW-1:0]        m_waddr, m_raddr;
    meta_t                m_wdata, m_rdata;
    logic                 s_we;
    logic [SW-1:0]        s_waddr, s_raddr;
    logic [GW-1:0]        s_wdata, s_rdata;

    logic [BYTES_W-1:0]   sum;
    logic [CLS_W-1:0]     need;
    logic [ADDR_W-1:0]    off;
    logic [31:0]          goff;
    logic [31:0]          ga;
    logic [KW-1:0]        nk;
    logic [GW-1:0]        upper;
    logic [63:0]          u64, f64;

    p2fla_ram #(.WIDTH($bits(meta_t)), .DEPTH(1 << GB)) u_meta (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    p2fla_ram #(.WIDTH(GW), .DEPTH(2 << GB)) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        req_next        = req_reg;
        faddr_next      = faddr_reg;
        need_k_next     = need_k_reg;
        k_next          = k_reg;
        g_next          = g_reg;
        clr_next        = clr_reg;
        used_next       = used_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        in_stall        = 1'b1;
        load            = 1'b0;
        cnt_idx         = k_reg;
        cnt_rd          = cnt_reg[cnt_idx];
        cnt_we          = 1'b0;
        cnt_wdata       = cnt_rd;
        m_we            = 1'b0;
        m_waddr         = g_reg;
        m_wdata         = '0;
        m_raddr         = g_reg;
        s_we            = 1'b0;
        s_waddr         = '0;
        s_wdata         = '0;
        s_raddr         = '0;
        sum             = BYTES_W'(req_reg) + BYTES_W'(HEADER_BYTES);
        need            = ceil_log2_17(sum);
        off             = faddr_reg - ADDR_W'(HEADER_BYTES);
        goff            = 32'(off) >> MIN_LOG;
        ga              = (32'(g_reg) << MIN_LOG) + 32'(HEADER_BYTES);
        nk              = k_reg - KW'(1);
        upper           = g_reg + GW'(GRAN_CNT >> (GB - int'(nk)));

        case (state_reg)
            S_CLR:
            begin
                m_we    = 1'b1;
                m_waddr = clr_reg;
                if (clr_reg == '0)
                begin
                    m_wdata = '{free: 1'b1, cls: CLS_W'(POOL_LOG)};
                end
                // the initial top-class block sits in the top class stack
                s_we     = (clr_reg == '0);
                s_waddr  = stk_base(TOP_K);
                clr_next = clr_reg + GW'(1);
                if (clr_reg == GW'(GRAN_CNT - SW'(1)))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    mode_next  = mode;
                    req_next   = request_bytes;
                    faddr_next = free_address;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                res_addr_next = '0;
                if (!mode_reg)
                begin
                    if (int'(need) > POOL_LOG)
                    begin
                        res_status_next = ST_NOMEM;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        need_k_next = (int'(need) < MIN_LOG) ? '0 : KW'(int'(need) - MIN_LOG);
                        k_next      = need_k_next;
                        state_next  = S_SRCH;
                    end
                end
                else if (faddr_reg == '0)
                begin
                    res_status_next = ST_OK;
                    state_next      = S_DONE;
                end
                else if (int'(faddr_reg) < HEADER_BYTES ||
                         (32'(off) & ((32'd1 << MIN_LOG) - 32'd1)) != '0 ||
                         goff >= (32'd1 << GB))
                begin
                    res_status_next = ST_BADFREE;
                    state_next      = S_DONE;
                end
                else
                begin
                    m_raddr    = GW'(goff);
                    g_next     = GW'(goff);
                    state_next = S_FCHK;
                end
            end
            S_SRCH:
            begin
                cnt_idx = k_reg;
                if (cnt_rd != '0)
                begin
                    s_raddr    = stk_base(k_reg) + cnt_rd - SW'(1);
                    cnt_we     = 1'b1;
                    cnt_wdata  = cnt_rd - SW'(1);
                    state_next = S_POP;
                end
                else if (k_reg == TOP_K)
                begin
                    res_status_next = ST_NOMEM;
                    state_next      = S_DONE;
                end
                else
                begin
                    k_next = k_reg + KW'(1);
                end
            end
            S_POP:
            begin
                g_next     = s_rdata;
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (k_reg == need_k_reg)
                begin
                    m_we            = 1'b1;
                    m_waddr         = g_reg;
                    m_wdata         = '{free: 1'b0, cls: CLS_W'(int'(k_reg) + MIN_LOG)};
                    used_next       = used_reg + (UW'(1) << (int'(k_reg) + MIN_LOG));
                    res_status_next = ST_OK;
                    res_addr_next   = ga[ADDR_W-1:0];
                    state_next      = S_DONE;
                end
                else
                begin
                    // halve: upper half goes free onto the next lower class
                    m_we    = 1'b1;
                    m_waddr = upper;
                    m_wdata = '{free: 1'b1, cls: CLS_W'(int'(nk) + MIN_LOG)};
                    cnt_idx = nk;
                    cnt_rd  = cnt_reg[cnt_idx];
                    if (cnt_rd < (GRAN_CNT >> nk))
                    begin
                        s_we      = 1'b1;
                        s_waddr   = stk_base(nk) + cnt_rd;
                        s_wdata   = upper;
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_rd + SW'(1);
                    end
                    k_next = nk;
                end
            end
            S_FCHK:
            begin
                res_addr_next = '0;
                state_next    = S_DONE;
                if (int'(m_rdata.cls) < MIN_LOG || int'(m_rdata.cls) > POOL_LOG ||
                    m_rdata.free)
                begin
                    res_status_next = ST_BADFREE;
                end
                else
                begin
                    res_status_next = ST_OK;
                    m_we      = 1'b1;
                    m_waddr   = g_reg;
                    m_wdata   = '{free: 1'b1, cls: m_rdata.cls};
                    used_next = used_reg - (UW'(1) << m_rdata.cls);
                    cnt_idx   = KW'(int'(m_rdata.cls) - MIN_LOG);
                    cnt_rd    = cnt_reg[cnt_idx];
                    if (cnt_rd < (GRAN_CNT >> cnt_idx))
                    begin
                        s_we      = 1'b1;
                        s_waddr   = stk_base(cnt_idx) + cnt_rd;
                        s_wdata   = g_reg;
                        cnt_we    = 1'b1;
                        cnt_wdata = cnt_rd + SW'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = load ? 1'b1 : (out_valid_reg && out_stall);
    assign u64 = 64'(used_reg);
    assign f64 = 64'(POOL_SIZE) - 64'(used_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            clr_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NC; i++)
            begin
                cnt_reg[i] <= (i == NC - 1) ? SW'(1) : '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            if (cnt_we)
            begin
                cnt_reg[cnt_idx] <= cnt_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg       <= mode_next;
        req_reg        <= req_next;
        faddr_reg      <= faddr_next;
        need_k_reg     <= need_k_next;
        k_reg          <= k_next;
        g_reg          <= g_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        if (load)
        begin
            status_reg       <= res_status_reg;
            data_address_reg <= res_addr_reg;
            used_bytes_reg   <= u64[BYTES_W-1:0];
            free_bytes_reg   <= f64[BYTES_W-1:0];
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign data_address = data_address_reg;
    assign used_bytes   = used_bytes_reg;
    assign free_bytes   = free_bytes_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= POOL_SIZE)
        else $error("used byte total exceeds pool");
    a_split_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SPLIT |-> k_reg >= need_k_reg)
        else $error("split below needed class");
    a_clr_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLR |-> !out_valid_reg)
        else $error("result during clearing pass");
    a_accept_dec: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_DEC)
        else $error("accepted beat not decoded");
    a_top_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[TOP_K] <= SW'(1))
        else $error("top class stack over capacity");
`endif

endmodule
